// ----- rtl/gbn_pkg.sv -----
// gbn_pkg: shared types and constants of the go-back-n sender window.
// Used by go_back_n_sender_window_unit and the testbench; depends on nothing.
package gbn_pkg;

  localparam int BUFFER_DEPTH = 16;
  localparam int MAX_WINDOW   = 8;

  // action codes of an input word
  localparam logic [1:0] ACT_IDLE    = 2'd0;
  localparam logic [1:0] ACT_OFFER   = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  // configuration register indexes
  localparam logic CFG_WINDOW_SIZE   = 1'b0;
  localparam logic CFG_TIMEOUT_TICKS = 1'b1;

  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] packet_tag;
    logic        ack_valid;
    logic        ack_positive;
    logic [31:0] ack_number;
  } in_word_t;

  typedef struct packed {
    logic        send_valid;
    logic [31:0] send_seq;
    logic [15:0] send_tag;
    logic        send_is_resend;
    logic        window_full;
    logic        timeout_fired;
    logic        ack_taken;
    logic [31:0] window_base;
    logic [31:0] next_sequence;
    logic [3:0]  in_flight;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RDTICK = 4'b0010,
    ST_RDTAG  = 4'b0100,
    ST_EXEC   = 4'b1000
  } state_t;

endpackage

// ----- rtl/gbn_ram.sv -----
// gbn_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing; instanced for the tag and send-tick stores.
module gbn_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/go_back_n_sender_window_unit.sv -----
// Result path: an accepted input word steps through ST_RDTICK, ST_RDTAG and ST_EXEC; the result
//   word is loaded when ST_EXEC executes, which waits while a held result word is stalled.
// Input flow: a new input word is taken only in idle, after the last one has executed; the
//   sequencer walks idle, base send-tick read, resend-tag read, execute; store reads are registered.
// Reset (rst_n low, synchronous): window empty, sequence numbers and tick 0,
//   window_size 8, timeout_ticks 10; the two stores keep undefined contents.
module go_back_n_sender_window_unit #(
  parameter int BufferDepth = gbn_pkg::BUFFER_DEPTH,  // power of two
  parameter int MaxWindow   = gbn_pkg::MAX_WINDOW
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  gbn_pkg::in_word_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output gbn_pkg::out_word_t              out_data,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [gbn_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int IDX_W = $clog2(BufferDepth);
  localparam int CNT_W = $clog2(MaxWindow + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [3:0]  win_size_r;
  logic [15:0] timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r <= 4'd8;
      timeout_r  <= 16'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        gbn_pkg::CFG_WINDOW_SIZE:   win_size_r <= cfg_wdata[3:0];
        gbn_pkg::CFG_TIMEOUT_TICKS: timeout_r  <= cfg_wdata[15:0];
        default:                    win_size_r <= win_size_r;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Window state, sequencer and the held input word
  // ---------------------------------------------------------------------------
  gbn_pkg::state_t   state_r, state_nxt;
  gbn_pkg::in_word_t item_r;
  logic [31:0]       base_seq_r, base_seq_nxt;
  logic [31:0]       next_seq_r, next_seq_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic [31:0]       tick_r, tick_nxt;
  logic              resend_active_r, resend_active_nxt;
  logic [31:0]       resend_pos_r, resend_pos_nxt;
  logic              tfired_r, tfired_nxt;
  logic              out_valid_r, out_valid_nxt;
  gbn_pkg::out_word_t out_data_r, out_data_nxt;

  logic in_acc;
  logic exec_go;

  assign in_stall = (state_r != gbn_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  // execute only when the output register is free or being emptied
  assign exec_go  = (state_r == gbn_pkg::ST_EXEC) && !(out_valid_r && out_stall);

  // ---------------------------------------------------------------------------
  // Stores: tag and last send tick per buffer slot
  // ---------------------------------------------------------------------------
  logic             tag_we, tick_we;
  logic [IDX_W-1:0] tag_waddr, tick_waddr, tag_raddr, tick_raddr;
  logic [15:0]      tag_wdata, tag_rdata;
  logic [31:0]      tick_wdata, tick_rdata;

  // store writes happen only on the executing cycle
  logic tag_we_q, tick_we_q;
  assign tag_we_q  = tag_we && exec_go;
  assign tick_we_q = tick_we && exec_go;

  gbn_ram #(.Width(16), .Depth(BufferDepth)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we_q),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  gbn_ram #(.Width(32), .Depth(BufferDepth)) u_tick_ram (
    .clk   (clk),
    .we    (tick_we_q),
    .waddr (tick_waddr),
    .wdata (tick_wdata),
    .raddr (tick_raddr),
    .rdata (tick_rdata)
  );

  // base slot's send tick is read while in ST_RDTICK, lands in ST_RDTAG
  assign tick_raddr = base_seq_r[IDX_W-1:0];

  // ---------------------------------------------------------------------------
  // Timeout check (ST_RDTAG): age of the base packet against the timeout
  // ---------------------------------------------------------------------------
  logic [31:0] base_age;
  logic        fire;
  logic [31:0] pos_sel;

  assign base_age = tick_r - tick_rdata;
  assign fire     = (out_cnt_r != '0) && (base_age >= {16'd0, timeout_r});
  assign pos_sel  = fire ? base_seq_r : resend_pos_r;
  // resend tag is read while in ST_RDTAG, lands in ST_EXEC
  assign tag_raddr = pos_sel[IDX_W-1:0];

  // ---------------------------------------------------------------------------
  // Execute (ST_EXEC): at most one transmission, then the cumulative ack
  // ---------------------------------------------------------------------------
  logic [CMP_W-1:0] ws_ext, win_eff;
  logic             offer;
  logic             sv, resend, wfull, taken;
  logic [31:0]      sseq;
  logic [15:0]      stag;
  logic [31:0]      x_next, x_pos, x_base;
  logic [CNT_W-1:0] x_cnt, ack_n;
  logic             x_active;
  logic [31:0]      ack_dist, ack_span, pos_off;

  assign ws_ext  = CMP_W'(win_size_r);
  // clamp the window register to 1..MaxWindow
  assign win_eff = (ws_ext == '0) ? CMP_W'(1) :
                   ((ws_ext > CMP_W'(MaxWindow)) ? CMP_W'(MaxWindow) : ws_ext);
  assign offer   = (item_r.action == gbn_pkg::ACT_OFFER) ||
                   (item_r.action == gbn_pkg::ACT_RESTART);

  always_comb begin
    sv         = 1'b0;
    resend     = 1'b0;
    wfull      = 1'b0;
    taken      = 1'b0;
    sseq       = '0;
    stag       = '0;
    x_next     = next_seq_r;
    x_pos      = resend_pos_r;
    x_base     = base_seq_r;
    x_cnt      = out_cnt_r;
    x_active   = resend_active_r;
    ack_n      = '0;
    tag_we     = 1'b0;
    tick_we    = 1'b0;
    tag_waddr  = next_seq_r[IDX_W-1:0];
    tag_wdata  = item_r.packet_tag;
    tick_waddr = next_seq_r[IDX_W-1:0];
    tick_wdata = tick_r;

    // transmission: resend first, else a new packet if the window has room
    if (resend_active_r && (out_cnt_r != '0)) begin
      if (resend_pos_r != next_seq_r) begin
        sv         = 1'b1;
        resend     = 1'b1;
        sseq       = resend_pos_r;
        stag       = tag_rdata;
        tick_we    = 1'b1;
        tick_waddr = resend_pos_r[IDX_W-1:0];
        x_pos      = resend_pos_r + 32'd1;
        if (x_pos == next_seq_r) begin
          x_active = 1'b0;
        end
      end else begin
        x_active = 1'b0;
      end
    end else if (offer) begin
      if (CMP_W'(out_cnt_r) >= win_eff) begin
        wfull = 1'b1;
      end else begin
        tag_we  = 1'b1;
        tick_we = 1'b1;
        sv      = 1'b1;
        sseq    = next_seq_r;
        stag    = item_r.packet_tag;
        x_next  = next_seq_r + 32'd1;
        x_cnt   = out_cnt_r + CNT_W'(1);
      end
    end

    // cumulative ack inside [base, next] slides the window in one step
    ack_dist = item_r.ack_number - base_seq_r;
    ack_span = x_next - base_seq_r;
    pos_off  = x_pos - base_seq_r;
    if (item_r.ack_valid && item_r.ack_positive && (ack_dist <= ack_span)) begin
      taken  = 1'b1;
      ack_n  = (ack_dist < 32'(x_cnt)) ? ack_dist[CNT_W-1:0] : x_cnt;
      x_base = base_seq_r + 32'(ack_n);
      x_cnt  = x_cnt - ack_n;
      if (x_active && (x_cnt == '0)) begin
        x_active = 1'b0;
      end
      if (x_active && (pos_off < 32'(ack_n))) begin
        x_pos = x_base;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Next-state logic
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt         = state_r;
    base_seq_nxt      = base_seq_r;
    next_seq_nxt      = next_seq_r;
    out_cnt_nxt       = out_cnt_r;
    tick_nxt          = tick_r;
    resend_active_nxt = resend_active_r;
    resend_pos_nxt    = resend_pos_r;
    tfired_nxt        = tfired_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_data_nxt      = out_data_r;

    case (state_r)
      gbn_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = gbn_pkg::ST_RDTICK;
          // restart clears the window and restarts the tick at 1 before the slot runs; else tick advances
          if (in_data.action == gbn_pkg::ACT_RESTART) begin
            base_seq_nxt      = '0;
            next_seq_nxt      = '0;
            out_cnt_nxt       = '0;
            resend_active_nxt = 1'b0;
            resend_pos_nxt    = '0;
            tick_nxt          = 32'd1;
          end else begin
            tick_nxt = tick_r + 32'd1;
          end
        end
      end
      gbn_pkg::ST_RDTICK: begin
        state_nxt = gbn_pkg::ST_RDTAG;
      end
      gbn_pkg::ST_RDTAG: begin
        state_nxt         = gbn_pkg::ST_EXEC;
        tfired_nxt        = fire;
        resend_active_nxt = fire || resend_active_r;
        resend_pos_nxt    = pos_sel;
      end
      gbn_pkg::ST_EXEC: begin
        if (exec_go) begin
          state_nxt         = gbn_pkg::ST_IDLE;
          base_seq_nxt      = x_base;
          next_seq_nxt      = x_next;
          out_cnt_nxt       = x_cnt;
          resend_active_nxt = x_active;
          resend_pos_nxt    = x_pos;
          out_valid_nxt     = 1'b1;
          out_data_nxt.send_valid     = sv;
          out_data_nxt.send_seq       = sseq;
          out_data_nxt.send_tag       = stag;
          out_data_nxt.send_is_resend = resend;
          out_data_nxt.window_full    = wfull;
          out_data_nxt.timeout_fired  = tfired_r;
          out_data_nxt.ack_taken      = taken;
          out_data_nxt.window_base    = x_base;
          out_data_nxt.next_sequence  = x_next;
          out_data_nxt.in_flight      = 4'(x_cnt);
        end
      end
      default: begin
        state_nxt = gbn_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= gbn_pkg::ST_IDLE;
      base_seq_r      <= '0;
      next_seq_r      <= '0;
      out_cnt_r       <= '0;
      tick_r          <= '0;
      resend_active_r <= 1'b0;
      resend_pos_r    <= '0;
      tfired_r        <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      base_seq_r      <= base_seq_nxt;
      next_seq_r      <= next_seq_nxt;
      out_cnt_r       <= out_cnt_nxt;
      tick_r          <= tick_nxt;
      resend_active_r <= resend_active_nxt;
      resend_pos_r    <= resend_pos_nxt;
      tfired_r        <= tfired_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // payload registers: hold the input word and the result word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  // window count never exceeds MaxWindow
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_cnt_r <= CNT_W'(MaxWindow))
    else $error("in-flight count above window limit");

  // the window span always equals the in-flight count
  a_span: assert property (@(posedge clk) disable iff (!rst_n)
    (next_seq_r - base_seq_r) == 32'(out_cnt_r))
    else $error("window span and in-flight count disagree");

  // go-back retransmission is only pending with packets outstanding
  a_resend: assert property (@(posedge clk) disable iff (!rst_n)
    resend_active_r |-> (out_cnt_r != '0))
    else $error("resend pending with empty window");

  // an execute step always leaves a result word behind
  a_exec_out: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> out_valid_r)
    else $error("execute step lost its result word");
`endif

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for go_back_n_sender_window_unit: directed, then random slots.
// A local go-back-n predictor supplies the expected result words.
// Depends on gbn_pkg and the unit under test.
module testbench;

  // action code 3 has no meaning and must behave as an idle slot
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD = 120;
  localparam int PHASE_WORDS = 130;
  localparam int NUM_PHASES = 9;

  typedef struct {
    gbn_pkg::in_word_t  stim;
    bit                 typed;
    gbn_pkg::out_word_t result;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  gbn_pkg::in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  gbn_pkg::out_word_t out_data;
  logic      cfg_we = 1'b0;
  logic      cfg_index = gbn_pkg::CFG_WINDOW_SIZE;
  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  go_back_n_sender_window_unit uut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_index, .cfg_wdata
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: sender window state and register copies, updated per accepted word
  // ---------------------------------------------------------------------------
  logic [3:0]  win_reg = 4'd8;
  logic [15:0] tmo_reg = 16'd10;
  logic [31:0] base_q, next_q, tick_q, resend_at;
  logic [3:0]  inflight_q;
  logic        resend_on;
  logic [15:0] tag_mem [gbn_pkg::BUFFER_DEPTH];
  logic [31:0] sent_at [gbn_pkg::BUFFER_DEPTH];

  gbn_pkg::out_word_t pending_results [$];
  stim_row_t   directed_rows [$];
  int unsigned mismatches = 0;
  int unsigned words_seen = 0;
  int          send_gap_max = 2;
  int          stall_max = 2;
  int          idle_cycles = 0;

  function automatic void clear_window();
    base_q = '0;
    next_q = '0;
    inflight_q = '0;
    tick_q = '0;
    resend_on = 1'b0;
    resend_at = '0;
  endfunction

  function automatic gbn_pkg::out_word_t predict_slot(gbn_pkg::in_word_t w);
    gbn_pkg::out_word_t r;
    logic [3:0]  limit;
    logic [31:0] age, ack_dist, span, slide, pos_off;
    int          idx;
    r = '0;
    limit = (win_reg == 4'd0) ? 4'd1 :
            ((win_reg > gbn_pkg::MAX_WINDOW) ? 4'(gbn_pkg::MAX_WINDOW) : win_reg);
    if (w.action == gbn_pkg::ACT_RESTART) clear_window();
    tick_q = tick_q + 1;
    // restart go-back from the base once the oldest word has waited long enough
    if (inflight_q != 0) begin
      age = tick_q - sent_at[base_q % gbn_pkg::BUFFER_DEPTH];
      if (age >= {16'd0, tmo_reg}) begin
        resend_on = 1'b1;
        resend_at = base_q;
        r.timeout_fired = 1'b1;
      end
    end
    if (resend_on && inflight_q != 0) begin
      if (resend_at != next_q) begin
        idx = resend_at % gbn_pkg::BUFFER_DEPTH;
        r.send_valid = 1'b1;
        r.send_is_resend = 1'b1;
        r.send_seq = resend_at;
        r.send_tag = tag_mem[idx];
        sent_at[idx] = tick_q;
        resend_at = resend_at + 1;
        if (resend_at == next_q) resend_on = 1'b0;
      end else begin
        resend_on = 1'b0;
      end
    end else if (w.action == gbn_pkg::ACT_OFFER || w.action == gbn_pkg::ACT_RESTART) begin
      if (inflight_q >= limit) begin
        r.window_full = 1'b1;
      end else begin
        idx = next_q % gbn_pkg::BUFFER_DEPTH;
        tag_mem[idx] = w.packet_tag;
        sent_at[idx] = tick_q;
        r.send_valid = 1'b1;
        r.send_seq = next_q;
        r.send_tag = w.packet_tag;
        next_q = next_q + 1;
        inflight_q = inflight_q + 4'd1;
      end
    end
    // cumulative ack inside [base, next] slides the window in one step
    if (w.ack_valid && w.ack_positive) begin
      ack_dist = w.ack_number - base_q;
      span = next_q - base_q;
      if (ack_dist <= span) begin
        slide = (ack_dist < {28'd0, inflight_q}) ? ack_dist : {28'd0, inflight_q};
        pos_off = resend_at - base_q;
        r.ack_taken = 1'b1;
        base_q = base_q + slide;
        inflight_q = inflight_q - slide[3:0];
        if (resend_on && inflight_q == 0) resend_on = 1'b0;
        if (resend_on && pos_off < slide) resend_at = base_q;
      end
    end
    r.window_base = base_q;
    r.next_sequence = next_q;
    r.in_flight = inflight_q;
    return r;
  endfunction

  // Random slot, shaped on the current window so that most acks land in range
  function automatic gbn_pkg::in_word_t draw_slot();
    gbn_pkg::in_word_t w;
    int          pick;
    logic [31:0] span;
    pick = $urandom_range(0, 99);
    if (pick < 65) w.action = gbn_pkg::ACT_OFFER;
    else if (pick < 88) w.action = gbn_pkg::ACT_IDLE;
    else if (pick < 97) w.action = ACT_UNUSED;
    else w.action = gbn_pkg::ACT_RESTART;
    w.packet_tag = 16'($urandom);
    w.ack_valid = ($urandom_range(0, 9) < 4);
    w.ack_positive = ($urandom_range(0, 9) < 8);
    span = next_q - base_q;
    pick = $urandom_range(0, 19);
    if (pick < 14) w.ack_number = base_q + $urandom_range(0, span);
    else if (pick < 16) w.ack_number = next_q + $urandom_range(1, 3);
    else w.ack_number = $urandom;
    return w;
  endfunction

  function automatic gbn_pkg::in_word_t slot(logic [1:0] act, logic [15:0] tag, logic av,
                                             logic ap, logic [31:0] num);
    gbn_pkg::in_word_t w;
    w.action = act;
    w.packet_tag = tag;
    w.ack_valid = av;
    w.ack_positive = ap;
    w.ack_number = num;
    return w;
  endfunction

  // Expected word for directed rows that carry no resend, full or timeout flag
  function automatic gbn_pkg::out_word_t typed_result(logic sv, logic [31:0] seq,
                                                      logic [15:0] tag, logic taken,
                                                      logic [31:0] base, logic [31:0] nxt,
                                                      logic [3:0] inflight);
    gbn_pkg::out_word_t r;
    r = '0;
    r.send_valid = sv;
    r.send_seq = seq;
    r.send_tag = tag;
    r.ack_taken = taken;
    r.window_base = base;
    r.next_sequence = nxt;
    r.in_flight = inflight;
    return r;
  endfunction

  function automatic void add_row(gbn_pkg::in_word_t w, bit typed, gbn_pkg::out_word_t r);
    stim_row_t row;
    row.stim = w;
    row.typed = typed;
    row.result = r;
    directed_rows.push_back(row);
  endfunction

  function automatic void show_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) $display("  %s: expected %h, got %h", name, want, got);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side: offer one word, hold it until taken, then draw the next gap
  // ---------------------------------------------------------------------------
  task automatic offer_word(input gbn_pkg::in_word_t w, input bit typed,
                            input gbn_pkg::out_word_t typed_exp);
    gbn_pkg::out_word_t predicted;
    int        gap;
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!(in_valid === 1'b1 && in_stall === 1'b0));
    predicted = predict_slot(w);
    pending_results.push_back(typed ? typed_exp : predicted);
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and pause until every expected word is back, then let the unit settle
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers on consecutive edges; wdata bits above the window field are noise
  task automatic write_settings(input logic [3:0] win, input logic [15:0] tmo);
    cfg_we <= 1'b1;
    cfg_index <= gbn_pkg::CFG_WINDOW_SIZE;
    cfg_wdata <= {12'($urandom), win};
    @(posedge clk);
    cfg_index <= gbn_pkg::CFG_TIMEOUT_TICKS;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_reg = win;
    tmo_reg = tmo;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stall per word, two long holds to back the unit up
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int        hold;
    gbn_pkg::out_word_t want;
    forever begin
      hold = (words_seen == 250 || words_seen == 800) ? LONG_HOLD
                                                      : $urandom_range(0, stall_max);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result word %0d arrived unexpected: %h", words_seen,
                                       out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result word %0d differs:", words_seen);
            show_field("send_valid", 32'(want.send_valid), 32'(out_data.send_valid));
            show_field("send_seq", want.send_seq, out_data.send_seq);
            show_field("send_tag", 32'(want.send_tag), 32'(out_data.send_tag));
            show_field("send_is_resend", 32'(want.send_is_resend),
                       32'(out_data.send_is_resend));
            show_field("window_full", 32'(want.window_full), 32'(out_data.window_full));
            show_field("timeout_fired", 32'(want.timeout_fired),
                       32'(out_data.timeout_fired));
            show_field("ack_taken", 32'(want.ack_taken), 32'(out_data.ack_taken));
            show_field("window_base", want.window_base, out_data.window_base);
            show_field("next_sequence", want.next_sequence, out_data.next_sequence);
            show_field("in_flight", 32'(want.in_flight), 32'(out_data.in_flight));
          end
        end
      end
      words_seen++;
    end
  end

  // End the run if neither channel moves a word for too long
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [3:0]  win_list [NUM_PHASES];
    logic [15:0] tmo_list [NUM_PHASES];
    gbn_pkg::out_word_t blank;
    blank = '0;
    win_list = '{4'd1, 4'd0, 4'd15, 4'd8, 4'd4, 4'd2, 4'd8, 4'd3, 4'd6};
    tmo_list = '{16'd1, 16'd0, 16'hFFFF, 16'd3, 16'd20, 16'd6, 16'd12, 16'd9, 16'd2};
    clear_window();
    foreach (tag_mem[i]) begin
      tag_mem[i] = '0;
      sent_at[i] = '0;
    end

    // Directed slots under the reset settings: window 8, timeout 10.
    // Empty slot, then two sends with the tag extremes.
    add_row(slot(gbn_pkg::ACT_IDLE, 16'h0000, 1'b0, 1'b0, 32'h0), 1'b1,
            typed_result(1'b0, 32'd0, 16'h0000, 1'b0, 32'd0, 32'd0, 4'd0));
    add_row(slot(gbn_pkg::ACT_OFFER, 16'hFFFF, 1'b0, 1'b0, 32'h0), 1'b1,
            typed_result(1'b1, 32'd0, 16'hFFFF, 1'b0, 32'd0, 32'd1, 4'd1));
    add_row(slot(gbn_pkg::ACT_OFFER, 16'h0000, 1'b0, 1'b0, 32'h0), 1'b1,
            typed_result(1'b1, 32'd1, 16'h0000, 1'b0, 32'd0, 32'd2, 4'd2));
    // Unused action acts as idle; an ack far beyond next is ignored
    add_row(slot(ACT_UNUSED, 16'h5555, 1'b1, 1'b1, 32'hFFFF_FFFF), 1'b1,
            typed_result(1'b0, 32'd0, 16'h0000, 1'b0, 32'd0, 32'd2, 4'd2));
    // Negative answer leaves the window alone
    add_row(slot(gbn_pkg::ACT_IDLE, 16'h0000, 1'b1, 1'b0, 32'd1), 1'b1,
            typed_result(1'b0, 32'd0, 16'h0000, 1'b0, 32'd0, 32'd2, 4'd2));
    add_row(slot(gbn_pkg::ACT_IDLE, 16'h0000, 1'b1, 1'b1, 32'd1), 1'b1,
            typed_result(1'b0, 32'd0, 16'h0000, 1'b1, 32'd1, 32'd2, 4'd1));
    // Send and ack in one slot, then fill the window and run into it
    add_row(slot(gbn_pkg::ACT_OFFER, 16'h1234, 1'b1, 1'b1, 32'd2), 1'b0, blank);
    add_row(slot(gbn_pkg::ACT_OFFER, 16'h8000, 1'b0, 1'b0, 32'd0), 1'b0, blank);
    add_row(slot(gbn_pkg::ACT_OFFER, 16'h0001, 1'b0, 1'b0, 32'd0), 1'b0, blank);
    add_row(slot(gbn_pkg::ACT_OFFER, 16'h7FFF, 1'b0, 1'b0, 32'd0), 1'b0, blank);
    add_row(slot(gbn_pkg::ACT_OFFER, 16'h5A5A, 1'b0, 1'b0, 32'd0), 1'b0, blank);
    add_row(slot(gbn_pkg::ACT_OFFER, 16'hC3C3, 1'b0, 1'b0, 32'd0), 1'b0, blank);
    add_row(slot(gbn_pkg::ACT_OFFER, 16'h0F0F, 1'b0, 1'b0, 32'd0), 1'b0, blank);
    add_row(slot(gbn_pkg::ACT_OFFER, 16'hF0F0, 1'b0, 1'b0, 32'd0), 1'b0, blank);
    add_row(slot(gbn_pkg::ACT_OFFER, 16'hBEEF, 1'b0, 1'b0, 32'd0), 1'b0, blank);
    add_row(slot(gbn_pkg::ACT_OFFER, 16'hDEAD, 1'b0, 1'b0, 32'd0), 1'b0, blank);
    // Idle until the base times out, then ack part way through the go-back
    add_row(slot(gbn_pkg::ACT_IDLE, 16'h0000, 1'b0, 1'b0, 32'd0), 1'b0, blank);
    add_row(slot(gbn_pkg::ACT_IDLE, 16'h0000, 1'b1, 1'b1, 32'd5), 1'b0, blank);
    // Positive flag without a valid answer, an ack below base, then ack everything
    add_row(slot(ACT_UNUSED, 16'h0000, 1'b0, 1'b1, 32'd7), 1'b0, blank);
    add_row(slot(gbn_pkg::ACT_IDLE, 16'h0000, 1'b1, 1'b1, 32'd0), 1'b0, blank);
    add_row(slot(gbn_pkg::ACT_IDLE, 16'h0000, 1'b1, 1'b1, 32'd10), 1'b0, blank);
    // Restart clears the window before the slot runs, the ack then covers seq 0
    add_row(slot(gbn_pkg::ACT_RESTART, 16'hA5A5, 1'b1, 1'b1, 32'd1), 1'b1,
            typed_result(1'b1, 32'd0, 16'hA5A5, 1'b1, 32'd1, 32'd1, 4'd0));
    add_row(slot(gbn_pkg::ACT_OFFER, 16'h0000, 1'b0, 1'b0, 32'd0), 1'b0, blank);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      offer_word(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].result);
    end
    wait_for_results();

    // Random phases: reprogram only once drained; vary the idling per phase so that
    // some phases run with no gaps on one side or the other
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_settings(win_list[p], tmo_list[p]);
      send_gap_max = (p % 3 == 0) ? 0 : 4;
      stall_max = (p % 2 == 0) ? 4 : 0;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        offer_word(draw_slot(), 1'b0, blank);
      end
      wait_for_results();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
